// ----- hdl/speck_block_cipher_macros.svh -----
// Assertion macros used by the SPECK cipher controller.
`ifndef SPECK_BLOCK_CIPHER_MACROS_SVH
`define SPECK_BLOCK_CIPHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/speck_pkg.sv -----
// Types and constants shared by the SPECK cipher controller, datapath and top level.
package speck_pkg;

  localparam int unsigned NUM_KEY_REGS = 4;
  localparam int unsigned KEY_REG_BITS = 16;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned BLOCK_BITS   = 32;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KLOAD,
    ST_EXPAND,
    ST_ROUND,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic key_load;
    logic exp_step;
    logic rk_re;
    logic blk_load;
    logic round_step;
    logic dec;
    logic out_load;
  } spk_cmd_t;

endpackage

// ----- hdl/speck_block_cipher.sv -----
// Top level of the SPECK block cipher core: controller and datapath.
//
//   Channel  Direction  Handshake                 Payload
//   cfg      in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//   in       in         in_valid_i / in_stall_o   cmd_i, block_data_i
//   out      out        out_valid_o / out_stall_i result_block_o
//
// Each block is taken in the idle state, goes through the single round unit once per round,
// and is moved into the output register in the finish state once that register is free or read.
// Round keys come from a memory read in the cycle before the round that uses them.
// After reset and after every key write the key registers are loaded and the key expansion
// runs, and the input channel stalls until it ends.
// A new beat is taken while the previous result still waits in the output register.
module speck_block_cipher #(
  parameter int unsigned WORD_BITS   = 16,
  parameter int unsigned ROUND_COUNT = 22,
  parameter int unsigned KEY_WORDS   = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [speck_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [speck_pkg::KEY_REG_BITS-1:0]  cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic [speck_pkg::BLOCK_BITS-1:0]    block_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [speck_pkg::BLOCK_BITS-1:0]    result_block_o
);

  localparam int unsigned CNT_BITS = $clog2(ROUND_COUNT);

  speck_pkg::spk_cmd_t  dp_cmd;
  logic [CNT_BITS-1:0]  step_idx;
  logic [CNT_BITS-1:0]  rk_raddr;

  speck_ctrl #(
    .ROUND_COUNT (ROUND_COUNT),
    .CNT_BITS    (CNT_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd),
    .step_idx_o  (step_idx),
    .rk_raddr_o  (rk_raddr)
  );

  speck_dp #(
    .WORD_BITS   (WORD_BITS),
    .ROUND_COUNT (ROUND_COUNT),
    .KEY_WORDS   (KEY_WORDS),
    .CNT_BITS    (CNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .block_data_i   (block_data_i),
    .cmd_i          (dp_cmd),
    .step_idx_i     (step_idx),
    .rk_raddr_i     (rk_raddr),
    .result_block_o (result_block_o)
  );

endmodule

// ----- hdl/speck_ctrl.sv -----
// Controller for the SPECK cipher: key expansion sequencing, round counting and output handshake.
module speck_ctrl #(
  parameter int unsigned ROUND_COUNT = 22,
  parameter int unsigned CNT_BITS    = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output speck_pkg::spk_cmd_t  cmd_o,
  output logic [CNT_BITS-1:0]  step_idx_o,
  output logic [CNT_BITS-1:0]  rk_raddr_o
);

  `include "speck_block_cipher_macros.svh"

  localparam logic [CNT_BITS-1:0] LAST_IDX = CNT_BITS'(ROUND_COUNT - 1);
  localparam logic [CNT_BITS-1:0] PREV_IDX = CNT_BITS'(ROUND_COUNT - 2);

  speck_pkg::state_e   state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                dec_q, dec_d;
  logic                ready_q, ready_d;
  logic                ov_q, ov_d;
  logic                accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= speck_pkg::ST_IDLE;
      cnt_q   <= '0;
      dec_q   <= 1'b0;
      ready_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dec_q   <= dec_d;
      ready_q <= ready_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    dec_d      = dec_q;
    ready_d    = ready_q && !cfg_we_i;
    cmd_o      = '0;
    cmd_o.dec  = dec_q;
    rk_raddr_o = cnt_q + CNT_BITS'(1);
    in_stall_o = 1'b1;
    accept     = 1'b0;
    unique case (state_q)
      speck_pkg::ST_IDLE: begin
        in_stall_o = !(ready_q && !cfg_we_i);
        if (cfg_we_i || !ready_q) begin
          state_d = speck_pkg::ST_KLOAD;
        end else if (in_valid_i) begin
          accept         = 1'b1;
          cmd_o.blk_load = 1'b1;
          cmd_o.rk_re    = 1'b1;
          rk_raddr_o     = (cmd_i == speck_pkg::OP_DECRYPT) ? LAST_IDX : '0;
          dec_d          = (cmd_i == speck_pkg::OP_DECRYPT);
          cnt_d          = '0;
          state_d        = speck_pkg::ST_ROUND;
        end
      end
      speck_pkg::ST_KLOAD: begin
        cmd_o.key_load = 1'b1;
        cnt_d          = '0;
        if (!cfg_we_i) begin
          state_d = speck_pkg::ST_EXPAND;
        end
      end
      speck_pkg::ST_EXPAND: begin
        cmd_o.exp_step = 1'b1;
        cnt_d          = cnt_q + CNT_BITS'(1);
        if (cfg_we_i) begin
          state_d = speck_pkg::ST_KLOAD;
        end else if (cnt_q == LAST_IDX) begin
          ready_d = 1'b1;
          state_d = speck_pkg::ST_IDLE;
        end
      end
      speck_pkg::ST_ROUND: begin
        cmd_o.round_step = 1'b1;
        cmd_o.rk_re      = (cnt_q != LAST_IDX);
        rk_raddr_o       = dec_q ? (PREV_IDX - cnt_q) : (cnt_q + CNT_BITS'(1));
        cnt_d            = cnt_q + CNT_BITS'(1);
        if (cnt_q == LAST_IDX) begin
          state_d = speck_pkg::ST_FINISH;
        end
      end
      speck_pkg::ST_FINISH: begin
        if (!ov_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = speck_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = speck_pkg::ST_IDLE;
      end
    endcase
    ov_d = cmd_o.out_load || (ov_q && out_stall_i);
  end

  assign step_idx_o  = cnt_q;
  assign out_valid_o = ov_q;

  `SPK_ASSERT_SAME(a_accept_ready, accept, ready_q && !cfg_we_i, "item accepted without schedule")
  `SPK_ASSERT_NEXT(a_accept_round, accept, (state_q == speck_pkg::ST_ROUND) && (cnt_q == '0),
                   "accepted item did not start at round zero")
  `SPK_ASSERT_NEXT(a_last_round, (state_q == speck_pkg::ST_ROUND) && (cnt_q == LAST_IDX),
                   state_q == speck_pkg::ST_FINISH, "round count overran")
  `SPK_ASSERT_NEXT(a_key_write_stale, cfg_we_i, !ready_q, "schedule marked ready after key write")

endmodule

// ----- hdl/speck_dp.sv -----
// Datapath for the SPECK cipher: key registers, key expansion, round-key memory and round unit.
module speck_dp #(
  parameter int unsigned WORD_BITS   = 16,
  parameter int unsigned ROUND_COUNT = 22,
  parameter int unsigned KEY_WORDS   = 4,
  parameter int unsigned CNT_BITS    = 5
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [speck_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [speck_pkg::KEY_REG_BITS-1:0]     cfg_wdata_i,
  input  logic [speck_pkg::BLOCK_BITS-1:0]       block_data_i,
  input  speck_pkg::spk_cmd_t                    cmd_i,
  input  logic [CNT_BITS-1:0]                    step_idx_i,
  input  logic [CNT_BITS-1:0]                    rk_raddr_i,
  output logic [speck_pkg::BLOCK_BITS-1:0]       result_block_o
);

  localparam int unsigned ROT_A = (WORD_BITS == 16) ? 7 : 8;
  localparam int unsigned ROT_B = (WORD_BITS == 16) ? 2 : 3;

  logic [speck_pkg::KEY_REG_BITS-1:0] key_q [speck_pkg::NUM_KEY_REGS];
  logic [WORD_BITS-1:0]               rk_mem [ROUND_COUNT];
  logic [WORD_BITS-1:0]               l_q [KEY_WORDS-1];
  logic [WORD_BITS-1:0]               k_q;
  logic [WORD_BITS-1:0]               rk_q;
  logic [WORD_BITS-1:0]               x_q, y_q;
  logic [WORD_BITS-1:0]               x_d, y_d;
  logic [WORD_BITS-1:0]               new_l;
  logic [WORD_BITS-1:0]               dec_y;
  logic [2*WORD_BITS-1:0]             blk_wide;
  logic [2*WORD_BITS-1:0]             res_wide;
  logic [speck_pkg::BLOCK_BITS-1:0]   res_q;

  function automatic logic [WORD_BITS-1:0] rotl(input logic [WORD_BITS-1:0] v,
                                                input int unsigned r);
    return (v << r) | (v >> (WORD_BITS - r));
  endfunction

  function automatic logic [WORD_BITS-1:0] rotr(input logic [WORD_BITS-1:0] v,
                                                input int unsigned r);
    return (v >> r) | (v << (WORD_BITS - r));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < speck_pkg::NUM_KEY_REGS; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  assign new_l = (k_q + rotr(l_q[0], ROT_A)) ^ WORD_BITS'(step_idx_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_load) begin
      k_q <= WORD_BITS'(key_q[0]);
      for (int j = 0; j < KEY_WORDS - 1; j++) begin
        l_q[j] <= WORD_BITS'(key_q[j+1]);
      end
    end else if (cmd_i.exp_step) begin
      k_q <= rotl(k_q, ROT_B) ^ new_l;
      for (int j = 0; j < KEY_WORDS - 2; j++) begin
        l_q[j] <= l_q[j+1];
      end
      l_q[KEY_WORDS-2] <= new_l;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_step) begin
      rk_mem[step_idx_i] <= k_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rk_re) begin
      rk_q <= rk_mem[rk_raddr_i];
    end
  end

  always_comb begin
    dec_y = rotr(x_q ^ y_q, ROT_B);
    if (cmd_i.dec) begin
      y_d = dec_y;
      x_d = rotl((x_q ^ rk_q) - dec_y, ROT_A);
    end else begin
      x_d = (rotr(x_q, ROT_A) + y_q) ^ rk_q;
      y_d = rotl(y_q, ROT_B) ^ x_d;
    end
  end

  assign blk_wide = (2 * WORD_BITS)'(block_data_i);
  assign res_wide = {y_q, x_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.blk_load) begin
      x_q <= blk_wide[WORD_BITS-1:0];
      y_q <= blk_wide[2*WORD_BITS-1:WORD_BITS];
    end else if (cmd_i.round_step) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q <= res_wide[speck_pkg::BLOCK_BITS-1:0];
    end
  end

  assign result_block_o = res_q;

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the SPECK32/64 block cipher core with its own cipher predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CFG_IDX_BITS = speck_pkg::CFG_IDX_BITS;
  localparam int unsigned KEY_REG_BITS = speck_pkg::KEY_REG_BITS;
  localparam int unsigned BLOCK_BITS   = speck_pkg::BLOCK_BITS;

  localparam int unsigned WORD_BITS   = 16;
  localparam int unsigned ROUND_COUNT = 22;
  localparam int unsigned KEY_WORDS   = 4;
  localparam int unsigned ROT_A       = 7;
  localparam int unsigned ROT_B       = 2;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned NUM_PHASES  = 7;
  localparam int unsigned PHASE_ITEMS = 100;

  localparam logic [CFG_IDX_BITS-1:0] REG_KEY0 = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY1 = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY3 = 2'd3;

  typedef enum logic {ROW_KEY, ROW_BLOCK} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic [15:0]             key_val;
    logic                    op;
    logic [BLOCK_BITS-1:0]   data;
    logic                    known;
    logic [BLOCK_BITS-1:0]   answer;
  } stim_row_t;

  localparam int unsigned DIR_COUNT = 23;
  localparam stim_row_t DIR_ROWS [DIR_COUNT] = '{
    '{ROW_BLOCK, REG_KEY0, 16'h0000, speck_pkg::OP_ENCRYPT, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0, 16'h0000, speck_pkg::OP_DECRYPT, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0, 16'h0000, speck_pkg::OP_ENCRYPT, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0, 16'h0000, speck_pkg::OP_DECRYPT, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0, 16'h0000, speck_pkg::OP_ENCRYPT, 32'h0000_FFFF, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0, 16'h0000, speck_pkg::OP_ENCRYPT, 32'hFFFF_0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0, 16'h0000, speck_pkg::OP_DECRYPT, 32'h8000_0001, 1'b0, 32'h0},
    '{ROW_KEY,   REG_KEY0, 16'h0100, speck_pkg::OP_ENCRYPT, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_KEY,   REG_KEY1, 16'h0908, speck_pkg::OP_ENCRYPT, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_KEY,   REG_KEY2, 16'h1110, speck_pkg::OP_ENCRYPT, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_KEY,   REG_KEY3, 16'h1918, speck_pkg::OP_ENCRYPT, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0, 16'h0000, speck_pkg::OP_ENCRYPT, 32'h694C_6574, 1'b1,
      32'h42F2_A868},
    '{ROW_BLOCK, REG_KEY0, 16'h0000, speck_pkg::OP_DECRYPT, 32'h42F2_A868, 1'b1,
      32'h694C_6574},
    '{ROW_BLOCK, REG_KEY0, 16'h0000, speck_pkg::OP_ENCRYPT, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0, 16'h0000, speck_pkg::OP_DECRYPT, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_KEY,   REG_KEY0, 16'hFFFF, speck_pkg::OP_ENCRYPT, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_KEY,   REG_KEY1, 16'hFFFF, speck_pkg::OP_ENCRYPT, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_KEY,   REG_KEY2, 16'hFFFF, speck_pkg::OP_ENCRYPT, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_KEY,   REG_KEY3, 16'hFFFF, speck_pkg::OP_ENCRYPT, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0, 16'h0000, speck_pkg::OP_ENCRYPT, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0, 16'h0000, speck_pkg::OP_DECRYPT, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0, 16'h0000, speck_pkg::OP_ENCRYPT, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_BLOCK, REG_KEY0, 16'h0000, speck_pkg::OP_DECRYPT, 32'hAAAA_5555, 1'b0, 32'h0}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [KEY_REG_BITS-1:0] cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    cmd_i;
  logic [BLOCK_BITS-1:0]   block_data_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [BLOCK_BITS-1:0]   result_block_o;

  logic [15:0]           key_shadow [KEY_WORDS];
  logic [15:0]           round_keys [ROUND_COUNT];
  logic [BLOCK_BITS-1:0] expected_blocks [$];
  logic [BLOCK_BITS-1:0] last_result;
  logic                  last_op;
  int unsigned           mismatch_count = 0;
  int unsigned           cycle_count = 0;
  bit                    hold_req;
  bit                    calm;

  speck_block_cipher #(
    .WORD_BITS  (WORD_BITS),
    .ROUND_COUNT(ROUND_COUNT),
    .KEY_WORDS  (KEY_WORDS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .block_data_i  (block_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_block_o(result_block_o)
  );

  function automatic logic [15:0] rotr16(input logic [15:0] w, input int unsigned n);
    return (w >> n) | (w << (WORD_BITS - n));
  endfunction

  function automatic logic [15:0] rotl16(input logic [15:0] w, input int unsigned n);
    return (w << n) | (w >> (WORD_BITS - n));
  endfunction

  function automatic void expand_round_keys();
    logic [15:0] lw [ROUND_COUNT + KEY_WORDS];
    logic [15:0] nl;
    for (int i = 0; i < KEY_WORDS - 1; i++) lw[i] = key_shadow[i + 1];
    round_keys[0] = key_shadow[0];
    for (int i = 0; i < ROUND_COUNT - 1; i++) begin
      nl = (round_keys[i] + rotr16(lw[i], ROT_A)) ^ 16'(i);
      lw[i + KEY_WORDS - 1] = nl;
      round_keys[i + 1] = rotl16(round_keys[i], ROT_B) ^ nl;
    end
  endfunction

  function automatic logic [BLOCK_BITS-1:0] speck_cipher(input logic op,
                                                         input logic [BLOCK_BITS-1:0] blk);
    logic [15:0] x;
    logic [15:0] y;
    x = blk[15:0];
    y = blk[31:16];
    if (op == speck_pkg::OP_ENCRYPT) begin
      for (int i = 0; i < ROUND_COUNT; i++) begin
        x = (rotr16(x, ROT_A) + y) ^ round_keys[i];
        y = rotl16(y, ROT_B) ^ x;
      end
    end else begin
      for (int i = ROUND_COUNT - 1; i >= 0; i--) begin
        y = rotr16(x ^ y, ROT_B);
        x = rotl16((x ^ round_keys[i]) - y, ROT_A);
      end
    end
    return {y, x};
  endfunction

  task automatic send_block(input logic op, input logic [BLOCK_BITS-1:0] data,
                            input logic known, input logic [BLOCK_BITS-1:0] answer);
    cmd_i        <= op;
    block_data_i <= data;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    last_result = known ? answer : speck_cipher(op, data);
    last_op     = op;
    expected_blocks = {expected_blocks, last_result};
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
  endtask

  task automatic key_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    key_shadow[idx] = val;
    expand_round_keys();
    repeat (ROUND_COUNT + 6) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %08h",
                 $time, result_block_o);
        mismatch_count++;
      end else if (result_block_o !== expected_blocks[0]) begin
        $display("%0t: result_block mismatch, expected %08h, actual %08h",
                 $time, expected_blocks[0], result_block_o);
        mismatch_count++;
        void'(expected_blocks.pop_front());
      end else begin
        void'(expected_blocks.pop_front());
      end
    end
  end

  initial begin
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 99) == 0) begin
        repeat ($urandom_range(100, 300)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned           gap_pct [NUM_PHASES];
    logic                  op;
    logic [BLOCK_BITS-1:0] data;
    int unsigned           pick;
    bit                    wrote;

    gap_pct        = '{0, 25, 10, 40, 0, 15, 30};
    hold_req       = 1'b0;
    calm           = 1'b0;
    last_result    = '0;
    last_op        = speck_pkg::OP_ENCRYPT;
    for (int k = 0; k < KEY_WORDS; k++) key_shadow[k] = '0;
    expand_round_keys();

    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_KEY0;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    cmd_i        <= speck_pkg::OP_ENCRYPT;
    block_data_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].kind == ROW_KEY) begin
        drain();
        key_write(DIR_ROWS[r].reg_idx, DIR_ROWS[r].key_val);
      end else begin
        send_block(DIR_ROWS[r].op, DIR_ROWS[r].data, DIR_ROWS[r].known, DIR_ROWS[r].answer);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 1) begin
        drain();
        for (int k = 0; k < KEY_WORDS; k++) key_write(CFG_IDX_BITS'(k), 16'h0000);
      end else if (p > 1) begin
        drain();
        wrote = 1'b0;
        for (int k = 0; k < KEY_WORDS; k++) begin
          if ($urandom_range(0, 1) == 1 || (k == KEY_WORDS - 1 && !wrote)) begin
            pick = $urandom_range(0, 5);
            key_write(CFG_IDX_BITS'(k), (pick == 0) ? 16'h0000 :
                                        (pick == 1) ? 16'hFFFF : 16'($urandom));
            wrote = 1'b1;
          end
        end
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == NUM_PHASES - 1 && n >= PHASE_ITEMS - 60) calm = 1'b1;
        if (p == 3 && n == 20) hold_req = 1'b1;
        if (p == 5 && n == 50) begin
          drain();
          @(posedge clk_i);
        end
        pick = $urandom_range(0, 9);
        op   = $urandom_range(0, 1) ? speck_pkg::OP_DECRYPT : speck_pkg::OP_ENCRYPT;
        if (pick == 0) begin
          data = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end else if (pick == 1) begin
          data = 32'h1 << $urandom_range(0, 31);
        end else if (pick <= 3) begin
          data = last_result;
          op   = (last_op == speck_pkg::OP_ENCRYPT) ? speck_pkg::OP_DECRYPT
                                                    : speck_pkg::OP_ENCRYPT;
        end else begin
          data = $urandom;
        end
        send_block(op, data, 1'b0, '0);
        if (!calm && $urandom_range(0, 99) < gap_pct[p]) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk_i);
        end
      end
    end

    drain();
    repeat (ROUND_COUNT + 10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/speck_pkg.sv
hdl/speck_ctrl.sv
hdl/speck_dp.sv
hdl/speck_block_cipher.sv
verif/tb.sv
